FILE: rtl/assert_macros.svh
// Assertion macros shared by the launcher feed sequencer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LFS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lfs assertion failed");

// Checked at every edge, reset included.
`define LFS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lfs assertion failed");

`endif

FILE: rtl/lfs_pkg.sv
// Types, register indexes and reset constants of the launcher feed sequencer.
// No dependencies; imported by every module of the block.
package lfs_pkg;

  localparam int unsigned SpdW   = 20;
  localparam int unsigned ThrW   = 19;
  localparam int unsigned BrakeW = 11;
  localparam int unsigned TickW  = 16;
  localparam int unsigned IdxW   = 3;

  localparam logic [BrakeW-1:0] BrakeMax = '1;
  localparam logic [TickW-1:0]  TickMax  = '1;

  // Register reset values
  localparam logic signed [SpdW-1:0] FirstSpeedRst   = 20'sd0;
  localparam logic signed [SpdW-1:0] SecondSpeedRst  = 20'sd0;
  localparam logic signed [SpdW-1:0] ConveyorUpRst   = 20'sd3200;
  localparam logic signed [SpdW-1:0] ConveyorDownRst = -20'sd6400;
  localparam logic [ThrW-1:0]        IdleThrRst      = 19'd80;
  localparam logic [ThrW-1:0]        MovingThrRst    = 19'd800;
  localparam logic [BrakeW-1:0]      StopLimitRst    = 11'd1000;
  localparam logic [TickW-1:0]       StartupRst      = 16'd5000;

  typedef enum logic [IdxW-1:0] {
    CFG_FIRST_SPEED  = 3'd0,
    CFG_SECOND_SPEED = 3'd1,
    CFG_CONVEYOR_UP  = 3'd2,
    CFG_CONVEYOR_DN  = 3'd3,
    CFG_IDLE_THR     = 3'd4,
    CFG_MOVING_THR   = 3'd5,
    CFG_STOP_LIMIT   = 3'd6,
    CFG_STARTUP      = 3'd7
  } cfg_idx_e;

  // Conveyor feed direction: reverse, idle, forward
  typedef enum logic [1:0] {
    DIR_IDLE = 2'b00,
    DIR_FWD  = 2'b01,
    DIR_REV  = 2'b11
  } feed_dir_e;

  typedef struct packed {
    logic signed [SpdW-1:0] first_speed;
    logic signed [SpdW-1:0] second_speed;
    logic signed [SpdW-1:0] conveyor_up;
    logic signed [SpdW-1:0] conveyor_down;
    logic [ThrW-1:0]        idle_threshold;
    logic [ThrW-1:0]        moving_threshold;
    logic [BrakeW-1:0]      stop_limit;
    logic [TickW-1:0]       startup_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   halt_req;
    logic                   aim_ready;
    logic signed [SpdW-1:0] friction_speed;
    logic signed [SpdW-1:0] conveyor_speed;
  } in_item_t;

  typedef struct packed {
    logic signed [SpdW-1:0] first_cmd;
    logic                   first_release;
    logic signed [SpdW-1:0] second_cmd;
    logic                   second_release;
    logic signed [SpdW-1:0] conveyor_cmd;
    logic                   conveyor_release;
    logic [TickW-1:0]       launches;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0]       elapsed_ticks;
    logic [BrakeW-1:0]      brake_count;
    logic                   feed_ready;
    feed_dir_e              feed_direction;
    logic                   block_moving;
    logic [TickW-1:0]       launch_total;
    logic signed [SpdW-1:0] hold;
    logic                   hold_release;
  } seq_state_t;

  // Magnitude of a signed speed; the most negative value maps to 2^19.
  function automatic logic [SpdW-1:0] spd_mag(input logic signed [SpdW-1:0] v);
    logic [SpdW-1:0] r;
    r = v[SpdW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

FILE: rtl/lfs_cfg.sv
// Configuration register file of the launcher feed sequencer.
// Depends on lfs_pkg.
module lfs_cfg import lfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IdxW-1:0]      cfg_index_i,
  input  logic [SpdW-1:0]      cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes, one per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_speed      <= FirstSpeedRst;
      cfg_q.second_speed     <= SecondSpeedRst;
      cfg_q.conveyor_up      <= ConveyorUpRst;
      cfg_q.conveyor_down    <= ConveyorDownRst;
      cfg_q.idle_threshold   <= IdleThrRst;
      cfg_q.moving_threshold <= MovingThrRst;
      cfg_q.stop_limit       <= StopLimitRst;
      cfg_q.startup_ticks    <= StartupRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_SPEED:  cfg_q.first_speed      <= signed'(cfg_data_i);
        CFG_SECOND_SPEED: cfg_q.second_speed     <= signed'(cfg_data_i);
        CFG_CONVEYOR_UP:  cfg_q.conveyor_up      <= signed'(cfg_data_i);
        CFG_CONVEYOR_DN:  cfg_q.conveyor_down    <= signed'(cfg_data_i);
        CFG_IDLE_THR:     cfg_q.idle_threshold   <= cfg_data_i[ThrW-1:0];
        CFG_MOVING_THR:   cfg_q.moving_threshold <= cfg_data_i[ThrW-1:0];
        CFG_STOP_LIMIT:   cfg_q.stop_limit       <= cfg_data_i[BrakeW-1:0];
        CFG_STARTUP:      cfg_q.startup_ticks    <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/lfs_step.sv
// Per-tick decision logic: friction wheel braking, conveyor homing and feed cycle.
// Depends on lfs_pkg; purely combinational, state is held by the top level.
module lfs_step import lfs_pkg::*; (
  input  cfg_t       cfg_i,
  input  seq_state_t st_i,
  input  in_item_t   item_i,
  output seq_state_t st_o,
  output out_item_t  res_o
);

  logic [SpdW-1:0]        fs_mag, cv_mag;
  logic                   cv_zero;
  logic signed [SpdW-1:0] down_adj, down_half;

  assign fs_mag  = spd_mag(item_i.friction_speed);
  assign cv_mag  = spd_mag(item_i.conveyor_speed);
  assign cv_zero = (item_i.conveyor_speed == '0);

  // Return speed halved, rounded toward zero
  assign down_adj  = cfg_i.conveyor_down + signed'({{(SpdW-1){1'b0}}, cfg_i.conveyor_down[SpdW-1]});
  assign down_half = {down_adj[SpdW-1], down_adj[SpdW-1:1]};

  always_comb begin
    seq_state_t nx;
    logic signed [SpdW-1:0] c1, c2;
    logic r1, r2;

    nx = st_i;
    c1 = '0;
    c2 = '0;
    r1 = 1'b1;
    r2 = 1'b1;

    if (st_i.elapsed_ticks != TickMax) begin
      nx.elapsed_ticks = st_i.elapsed_ticks + 1'b1;
    end

    if (item_i.halt_req) begin
      nx.hold         = '0;
      nx.hold_release = 1'b1;
    end else begin
      // Friction wheels
      if (item_i.aim_ready) begin
        c1 = cfg_i.first_speed;
        c2 = cfg_i.second_speed;
        r1 = 1'b0;
        r2 = 1'b0;
        nx.brake_count = '0;
      end else if (fs_mag <= {1'b0, cfg_i.idle_threshold} ||
                   st_i.brake_count > cfg_i.stop_limit) begin
        r1 = 1'b1;
        r2 = 1'b1;
      end else begin
        r1 = 1'b0;
        r2 = 1'b0;
        if (st_i.brake_count != BrakeMax) begin
          nx.brake_count = st_i.brake_count + 1'b1;
        end
      end

      // Conveyor: homing, then the push / reverse / ready cycle
      if (st_i.launch_total == '0 && st_i.elapsed_ticks < cfg_i.startup_ticks) begin
        nx.hold         = down_half;
        nx.hold_release = 1'b0;
      end else begin
        if (st_i.launch_total == '0) begin
          nx.hold           = '0;
          nx.hold_release   = 1'b1;
          nx.feed_ready     = 1'b1;
          nx.feed_direction = DIR_IDLE;
        end
        if (cv_mag > {1'b0, cfg_i.moving_threshold}) begin
          nx.block_moving = 1'b1;
        end
        if (nx.feed_ready) begin
          if (item_i.aim_ready) begin
            nx.hold           = cfg_i.conveyor_up;
            nx.hold_release   = 1'b0;
            nx.feed_direction = DIR_FWD;
          end else begin
            nx.block_moving = 1'b0;
          end
        end
        // Push finished: count the launch and reverse
        if (nx.feed_direction == DIR_FWD && nx.block_moving && cv_zero) begin
          nx.feed_ready = 1'b0;
          if (nx.launch_total != TickMax) begin
            nx.launch_total = nx.launch_total + 1'b1;
          end
          nx.feed_direction = DIR_REV;
          nx.block_moving   = 1'b0;
        end
        if (nx.feed_direction == DIR_REV) begin
          nx.hold         = cfg_i.conveyor_down;
          nx.hold_release = 1'b0;
          if (nx.block_moving && cv_zero) begin
            nx.hold           = '0;
            nx.hold_release   = 1'b1;
            nx.block_moving   = 1'b0;
            nx.feed_ready     = 1'b1;
            nx.feed_direction = DIR_IDLE;
          end
        end
        if (nx.feed_direction == DIR_IDLE) begin
          nx.hold         = '0;
          nx.hold_release = 1'b1;
        end
      end
    end

    st_o = nx;
    res_o.first_cmd        = c1;
    res_o.first_release    = r1;
    res_o.second_cmd       = c2;
    res_o.second_release   = r2;
    res_o.conveyor_cmd     = nx.hold_release ? '0 : nx.hold;
    res_o.conveyor_release = nx.hold_release;
    res_o.launches         = nx.launch_total;
  end

endmodule

FILE: rtl/launcher_feed_sequencer_top.sv
// Top level of the launcher feed sequencer: input register, state, result register.
// Depends on lfs_pkg, assert_macros.svh, lfs_cfg and lfs_step.

// One item per control tick produces exactly one result. An item is taken into
// an input register, decided combinationally by the tick logic against the
// stored sequencer state, and its result lands in the output register when
// that register is empty or being drained, and is offered from there. A new
// item is accepted every cycle; the only thing that holds items back is the
// output stall, which backs up through the two registers. Configuration
// registers are always ready and take effect for the next item decided. Reset
// brings the block up in conveyor homing with all motors released.
`include "assert_macros.svh"

module launcher_feed_sequencer_top import lfs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [SpdW-1:0] cfg_data_i
);

  cfg_t       cfg;
  in_item_t   in_q;
  logic       in_vld_q;
  out_item_t  out_q, res;
  logic       out_vld_q;
  seq_state_t st_q, st_d;
  logic       adv;

  lfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfs_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // Input stage moves on when the result register is empty or being drained
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Sequencer state, updated once per decided item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.elapsed_ticks  <= '0;
      st_q.brake_count    <= '0;
      st_q.feed_ready     <= 1'b0;
      st_q.feed_direction <= DIR_REV;
      st_q.block_moving   <= 1'b0;
      st_q.launch_total   <= '0;
      st_q.hold           <= '0;
      st_q.hold_release   <= 1'b1;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  `LFS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !in_vld_q && !out_vld_q)
  `LFS_ASSERT(a_state_holds, clk_i, rst_ni, !adv |=> $stable(st_q))
  `LFS_ASSERT(a_result_follows, clk_i, rst_ni, adv |=> out_vld_q)
  `LFS_ASSERT(a_launch_monotonic, clk_i, rst_ni,
              1'b1 |=> st_q.launch_total >= $past(st_q.launch_total))
  `LFS_ASSERT(a_released_zero, clk_i, rst_ni, st_q.hold_release |-> st_q.hold == '0)

endmodule

FILE: tb/sv/lfs_feed_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the launcher feed sequencer: mirrors the tick logic and checks each result.
// Depends on lfs_pkg; instantiated beside the block by launcher_feed_sequencer_top_tb.
module lfs_feed_checker import lfs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  in_item_t        in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  out_item_t       out_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [SpdW-1:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              checked_o,
  output int              launches_o
);

  // Shadow registers and sequencer state
  cfg_t                   regs;
  logic [TickW-1:0]       tick_cnt;
  logic [BrakeW-1:0]      brake_cnt;
  logic                   feed_armed;
  feed_dir_e              feed_dir;
  logic                   push_moving;
  logic [TickW-1:0]       launch_cnt;
  logic signed [SpdW-1:0] conv_hold;
  logic                   conv_released;

  out_item_t expected_cmds[$];
  out_item_t next_cmd;
  int        mismatches = 0;
  int        checked = 0;

  assign fail_count_o = mismatches;
  assign checked_o    = checked;
  assign launches_o   = int'(launch_cnt);

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: result %0d: %s", $time, checked, msg);
    end
  endtask

  function automatic int speed_abs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic hold_to(input int v);
    conv_hold     = v[SpdW-1:0];
    conv_released = 1'b0;
  endtask

  task automatic hold_off();
    conv_hold     = '0;
    conv_released = 1'b1;
  endtask

  // Push, reverse and ready cycle of the conveyor
  task automatic step_feed(input logic guide, input int cv);
    if (speed_abs(cv) > int'(regs.moving_threshold)) push_moving = 1'b1;
    if (feed_armed) begin
      if (guide) begin
        hold_to($signed(regs.conveyor_up));
        feed_dir = DIR_FWD;
      end else begin
        push_moving = 1'b0;
      end
    end
    // block has stopped at the end of the push: one launch done
    if (feed_dir == DIR_FWD && push_moving && cv == 0) begin
      feed_armed = 1'b0;
      if (launch_cnt != TickMax) launch_cnt++;
      feed_dir    = DIR_REV;
      push_moving = 1'b0;
    end
    if (feed_dir == DIR_REV) begin
      hold_to($signed(regs.conveyor_down));
      if (push_moving && cv == 0) begin
        hold_off();
        push_moving = 1'b0;
        feed_armed  = 1'b1;
        feed_dir    = DIR_IDLE;
      end
    end
    if (feed_dir == DIR_IDLE) hold_off();
  endtask

  // One control tick: wheel commands, homing or feed, then the result
  task automatic tick_sequencer(input in_item_t it, output out_item_t res);
    int                     fs;
    int                     cv;
    int                     now_ticks;
    logic signed [SpdW-1:0] c1;
    logic signed [SpdW-1:0] c2;
    logic                   r1;
    logic                   r2;
    fs        = $signed(it.friction_speed);
    cv        = $signed(it.conveyor_speed);
    now_ticks = int'(tick_cnt);
    c1        = '0;
    c2        = '0;
    r1        = 1'b1;
    r2        = 1'b1;
    if (tick_cnt != TickMax) tick_cnt++;

    if (it.halt_req) begin
      hold_off();
    end else begin
      if (it.aim_ready) begin
        c1        = regs.first_speed;
        c2        = regs.second_speed;
        r1        = 1'b0;
        r2        = 1'b0;
        brake_cnt = '0;
      end else if (speed_abs(fs) <= int'(regs.idle_threshold) ||
                   brake_cnt > regs.stop_limit) begin
        r1 = 1'b1;
        r2 = 1'b1;
      end else begin
        r1 = 1'b0;
        r2 = 1'b0;
        if (brake_cnt != BrakeMax) brake_cnt++;
      end

      if (launch_cnt == 0 && now_ticks < int'(regs.startup_ticks)) begin
        // homing at half the return speed, truncated toward zero
        hold_to(int'($signed(regs.conveyor_down)) / 2);
      end else begin
        if (launch_cnt == 0) begin
          hold_off();
          feed_armed = 1'b1;
          feed_dir   = DIR_IDLE;
        end
        step_feed(it.aim_ready, cv);
      end
    end

    res.first_cmd        = c1;
    res.first_release    = r1;
    res.second_cmd       = c2;
    res.second_release   = r2;
    res.conveyor_cmd     = conv_released ? '0 : conv_hold;
    res.conveyor_release = conv_released;
    res.launches         = launch_cnt;
  endtask

  task automatic write_shadow(input logic [IdxW-1:0] idx, input logic [SpdW-1:0] d);
    case (cfg_idx_e'(idx))
      CFG_FIRST_SPEED:  regs.first_speed      = d;
      CFG_SECOND_SPEED: regs.second_speed     = d;
      CFG_CONVEYOR_UP:  regs.conveyor_up      = d;
      CFG_CONVEYOR_DN:  regs.conveyor_down    = d;
      CFG_IDLE_THR:     regs.idle_threshold   = d[ThrW-1:0];
      CFG_MOVING_THR:   regs.moving_threshold = d[ThrW-1:0];
      CFG_STOP_LIMIT:   regs.stop_limit       = d[BrakeW-1:0];
      CFG_STARTUP:      regs.startup_ticks    = d[TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    if (got.first_cmd !== want.first_cmd)
      report_mismatch($sformatf("first_cmd got %0d expected %0d",
                                $signed(got.first_cmd), $signed(want.first_cmd)));
    if (got.first_release !== want.first_release)
      report_mismatch($sformatf("first_release got %0b expected %0b",
                                got.first_release, want.first_release));
    if (got.second_cmd !== want.second_cmd)
      report_mismatch($sformatf("second_cmd got %0d expected %0d",
                                $signed(got.second_cmd), $signed(want.second_cmd)));
    if (got.second_release !== want.second_release)
      report_mismatch($sformatf("second_release got %0b expected %0b",
                                got.second_release, want.second_release));
    if (got.conveyor_cmd !== want.conveyor_cmd)
      report_mismatch($sformatf("conveyor_cmd got %0d expected %0d",
                                $signed(got.conveyor_cmd), $signed(want.conveyor_cmd)));
    if (got.conveyor_release !== want.conveyor_release)
      report_mismatch($sformatf("conveyor_release got %0b expected %0b",
                                got.conveyor_release, want.conveyor_release));
    if (got.launches !== want.launches)
      report_mismatch($sformatf("launches got %0d expected %0d",
                                got.launches, want.launches));
  endtask

  // Watch all three channels; each transfer is taken at the edge it happens on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.first_speed      = FirstSpeedRst;
      regs.second_speed     = SecondSpeedRst;
      regs.conveyor_up      = ConveyorUpRst;
      regs.conveyor_down    = ConveyorDownRst;
      regs.idle_threshold   = IdleThrRst;
      regs.moving_threshold = MovingThrRst;
      regs.stop_limit       = StopLimitRst;
      regs.startup_ticks    = StartupRst;
      tick_cnt      = '0;
      brake_cnt     = '0;
      feed_armed    = 1'b0;
      feed_dir      = DIR_REV;
      push_moving   = 1'b0;
      launch_cnt    = '0;
      conv_hold     = '0;
      conv_released = 1'b1;
      expected_cmds.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        tick_sequencer(in_data_i, next_cmd);
        expected_cmds.push_back(next_cmd);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          next_cmd = expected_cmds.pop_front();
          compare_result(out_data_i, next_cmd);
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_shadow(cfg_index_i, cfg_data_i);
      pending_o <= expected_cmds.size();
    end
  end

endmodule

FILE: tb/sv/launcher_feed_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the launcher feed sequencer: homing, braking and launch cycles.
// Depends on lfs_pkg, launcher_feed_sequencer_top and lfs_feed_checker.
module launcher_feed_sequencer_top_tb;
  import lfs_pkg::*;

  localparam int CycleLimit = 5_000_000;
  localparam int SoakItems  = 240;
  localparam int PhaseItems = 115;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  in_item_t        in_data   = '0;
  logic            out_stall = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [SpdW-1:0] cfg_data  = '0;
  logic            in_stall;
  logic            out_valid;
  out_item_t       out_data;
  logic            cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int launches;

  cfg_t active_cfg;
  int   burst_left = 0;
  bit   fast_feed  = 1'b0;
  int   sent       = 0;
  int   settings_loaded = 0;
  int   cycle_cnt  = 0;

  always #6 clk = ~clk;

  launcher_feed_sequencer_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  lfs_feed_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .launches_o   (launches)
  );

  // Receiver stall: runs of no stall, light, heavy and solid stall
  int stall_mode = 0;
  int mode_left  = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(4, 60);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("** launcher_feed_sequencer_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [SpdW-1:0] rnd20();
    logic [31:0] r;
    r = $urandom;
    return r[SpdW-1:0];
  endfunction

  function automatic in_item_t tick_item(input logic stop, input logic guide,
                                         input int fs, input int cv);
    in_item_t it;
    it.halt_req       = stop;
    it.aim_ready      = guide;
    it.friction_speed = fs[SpdW-1:0];
    it.conveyor_speed = cv[SpdW-1:0];
    return it;
  endfunction

  // Friction speed: full range, near the idle threshold, extremes or small
  function automatic int friction_pick();
    int v;
    case ($urandom_range(0, 3))
      0: return $signed(rnd20());
      1: begin
        v = int'(active_cfg.idle_threshold) + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v >= 524288) return -524288;
        return $urandom_range(0, 1) ? v : -v;
      end
      2: begin
        case ($urandom_range(0, 2))
          0:       return -524288;
          1:       return 524287;
          default: return 0;
        endcase
      end
      default: return $urandom_range(0, 400) - 200;
    endcase
  endfunction

  // Conveyor speed that mostly counts as moving under the current threshold
  function automatic int conveyor_moving();
    int m;
    if ($urandom_range(0, 3) == 0) return $signed(rnd20());
    m = int'(active_cfg.moving_threshold) + 1 + $urandom_range(0, 4000);
    if (m >= 524288) return -524288;
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t        s;
    logic [31:0] r;
    s.first_speed   = rnd20();
    s.second_speed  = rnd20();
    s.conveyor_up   = rnd20();
    s.conveyor_down = rnd20();
    r = $urandom;
    s.idle_threshold   = ($urandom_range(0, 3) == 0) ? r[ThrW-1:0]
                                                      : ThrW'($urandom_range(0, 3000));
    r = $urandom;
    s.moving_threshold = ($urandom_range(0, 3) == 0) ? r[ThrW-1:0]
                                                      : ThrW'($urandom_range(0, 3000));
    r = $urandom;
    s.stop_limit    = $urandom_range(0, 1) ? BrakeW'($urandom_range(0, 12)) : r[BrakeW-1:0];
    r = $urandom;
    s.startup_ticks = r[TickW-1:0];
    return s;
  endfunction

  // One input transfer; bursts of items separated by random gaps
  task automatic push_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = fast_feed ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Stop feeding and wait until every expected result has arrived
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write all eight registers back to back while the block is idle
  task automatic load_settings(input cfg_t s);
    cfg_idx_e        idx;
    logic [SpdW-1:0] word;
    settle();
    idx = idx.first();
    do begin
      word = rnd20();  // bits above a narrow register's width are junk
      case (idx)
        CFG_FIRST_SPEED:  word = s.first_speed;
        CFG_SECOND_SPEED: word = s.second_speed;
        CFG_CONVEYOR_UP:  word = s.conveyor_up;
        CFG_CONVEYOR_DN:  word = s.conveyor_down;
        CFG_IDLE_THR:     word[ThrW-1:0] = s.idle_threshold;
        CFG_MOVING_THR:   word[ThrW-1:0] = s.moving_threshold;
        CFG_STOP_LIMIT:   word[BrakeW-1:0] = s.stop_limit;
        default:          word[TickW-1:0] = s.startup_ticks;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word;
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
    active_cfg = s;
    settings_loaded++;
  endtask

  // Launch cycles with random content, mixed with noise items
  task automatic run_feed_cycles(input int count);
    int   n;
    int   k;
    int   seg;
    logic guide;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $signed(rnd20()), $signed(rnd20())));
        n++;
      end else begin
        // push then reverse: moving stretch, then the block stops
        for (seg = 0; seg < 2; seg++) begin
          k = $urandom_range(1, 3);
          repeat (k) begin
            guide = (seg == 0) ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
            push_item(tick_item($urandom_range(0, 24) == 0, guide,
                                friction_pick(), conveyor_moving()));
            n++;
          end
          guide = (seg == 0) ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
          push_item(tick_item($urandom_range(0, 24) == 0, guide, friction_pick(), 0));
          n++;
        end
      end
    end
  endtask

  initial begin
    cfg_t s;
    logic guide;
    int   i;

    active_cfg.first_speed      = FirstSpeedRst;
    active_cfg.second_speed     = SecondSpeedRst;
    active_cfg.conveyor_up      = ConveyorUpRst;
    active_cfg.conveyor_down    = ConveyorDownRst;
    active_cfg.idle_threshold   = IdleThrRst;
    active_cfg.moving_threshold = MovingThrRst;
    active_cfg.stop_limit       = StopLimitRst;
    active_cfg.startup_ticks    = StartupRst;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, homing: stop, guide, idle threshold edges, speed extremes
    push_item(tick_item(1'b0, 1'b0, 0, 0));
    push_item(tick_item(1'b1, 1'b1, 524287, -524288));
    push_item(tick_item(1'b0, 1'b1, -524288, 524287));
    push_item(tick_item(1'b0, 1'b0, 80, 0));
    push_item(tick_item(1'b0, 1'b0, -80, 0));
    push_item(tick_item(1'b0, 1'b0, 81, 100));
    push_item(tick_item(1'b0, 1'b0, -524288, -524288));
    push_item(tick_item(1'b0, 1'b0, 524287, 524287));
    push_item(tick_item(1'b1, 1'b0, 0, 0));
    push_item(tick_item(1'b0, 1'b1, 0, 1));

    // Homing stretch: braking that never ends by count,
    // odd return speed halves toward zero
    s.first_speed      = -20'sd524288;
    s.second_speed     = 20'sd524287;
    s.conveyor_up      = 20'sd3200;
    s.conveyor_down    = -20'sd524287;
    s.idle_threshold   = '0;
    s.moving_threshold = 19'd800;
    s.stop_limit       = BrakeMax;
    s.startup_ticks    = TickMax;
    load_settings(s);
    fast_feed = 1'b1;
    for (i = 0; i < SoakItems; i++) begin
      guide = (i >= 100 && i < 140);
      push_item(tick_item($urandom_range(0, 49) == 0, guide,
                          ($urandom_range(0, 31) == 0) ? 0 : $signed(rnd20()),
                          $signed(rnd20())));
    end
    fast_feed = 1'b0;

    // Braking ends by count, then a first launch and return
    s.first_speed      = -20'sd524288;
    s.second_speed     = 20'sd524287;
    s.conveyor_up      = 20'sd524287;
    s.conveyor_down    = -20'sd524288;
    s.idle_threshold   = '0;
    s.moving_threshold = '0;
    s.stop_limit       = 11'd2;
    s.startup_ticks    = '0;
    load_settings(s);
    push_item(tick_item(1'b0, 1'b1, 1000, 0));
    repeat (4) push_item(tick_item(1'b0, 1'b0, 1000, 0));
    push_item(tick_item(1'b0, 1'b1, 0, 5));
    push_item(tick_item(1'b0, 1'b1, 0, 0));
    push_item(tick_item(1'b0, 1'b0, 0, -7));
    push_item(tick_item(1'b0, 1'b0, 0, 0));

    // Random launch cycles under nominal, all-zero, extreme and random settings
    s.first_speed      = 20'sd1600;
    s.second_speed     = -20'sd1600;
    s.conveyor_up      = 20'sd3200;
    s.conveyor_down    = -20'sd6400;
    s.idle_threshold   = 19'd80;
    s.moving_threshold = 19'd800;
    s.stop_limit       = 11'd1000;
    s.startup_ticks    = 16'd5000;
    load_settings(s);
    run_feed_cycles(PhaseItems);

    load_settings('0);
    run_feed_cycles(PhaseItems);

    s.first_speed      = 20'sd524287;
    s.second_speed     = -20'sd524288;
    s.conveyor_up      = -20'sd524288;
    s.conveyor_down    = 20'sd524287;
    s.idle_threshold   = '1;
    s.moving_threshold = '1;
    s.stop_limit       = BrakeMax;
    s.startup_ticks    = TickMax;
    load_settings(s);
    run_feed_cycles(PhaseItems);

    s = random_settings();
    s.idle_threshold   = 19'd100;
    s.moving_threshold = 19'd50;
    s.stop_limit       = 11'd5;
    load_settings(s);
    run_feed_cycles(PhaseItems);

    repeat (2) begin
      load_settings(random_settings());
      run_feed_cycles(PhaseItems);
    end

    // Drain, then a short tail to catch stray results
    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings (a homing stretch included).",
             sent, settings_loaded);
    $display("Checked %0d results, %0d launches counted, %0d mismatches.",
             checked, launches, fail_count);
    if (fail_count == 0) begin
      $display("** launcher_feed_sequencer_top: PASSED **");
    end else begin
      $display("** launcher_feed_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule
